[design/mcc_pkg.sv]
// Shared types and codes for the MOESI snooping cache controller.
// No dependencies; every other design file uses this package.
`default_nettype none

package mcc_pkg;

	localparam int NUM_SETS_DEF  = 128;
	localparam int NUM_WAYS_DEF  = 4;
	localparam int ADDR_BITS_DEF = 32;

	localparam int LINE_SHIFT = 5;
	localparam int ADDR_W     = 32;
	localparam int ID_W       = 4;
	localparam int CFG_AW     = 3;
	localparam int APB_DW     = 32;

	// item action codes
	localparam logic [2:0] ACT_RD    = 3'd0;
	localparam logic [2:0] ACT_WR    = 3'd1;
	localparam logic [2:0] ACT_SNOOP = 3'd2;
	localparam logic [2:0] ACT_ACK   = 3'd3;
	localparam logic [2:0] ACT_DONE  = 3'd4;

	// bus operation codes, shared by snoops and issued requests
	localparam logic [1:0] BUS_PRD  = 2'd0;
	localparam logic [1:0] BUS_PWR  = 2'd1;
	localparam logic [1:0] BUS_XFER = 2'd2;
	localparam logic [1:0] BUS_NONE = 2'd3;

	localparam logic [1:0] TGT_ALL = 2'd0;
	localparam logic [1:0] TGT_MEM = 2'd1;
	localparam logic [1:0] TGT_ONE = 2'd2;

	localparam logic [1:0] OUT_DONE = 2'd0;
	localparam logic [1:0] OUT_REQ  = 2'd1;
	localparam logic [1:0] OUT_BUSY = 2'd2;

	// line coherence states
	localparam logic [2:0] ST_I = 3'd0;
	localparam logic [2:0] ST_S = 3'd1;
	localparam logic [2:0] ST_E = 3'd2;
	localparam logic [2:0] ST_O = 3'd3;
	localparam logic [2:0] ST_M = 3'd4;

	localparam logic [CFG_AW-1:0] REG_CACHE_ID = 3'd0;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_WB_ACK,
		PH_WB_DATA,
		PH_FILL_ACK,
		PH_FILL_DATA,
		PH_UPH_ACK,
		PH_UPM_ACK
	} phase_t;

	typedef enum logic [1:0] {
		CS_CLEAR,
		CS_IDLE,
		CS_EXEC
	} ctl_state_t;

	typedef struct packed {
		logic load;
		logic clear;
		logic commit;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_done;
		logic out_blocked;
	} dp_status_t;

endpackage

`default_nettype wire

[design/mcc_in_if.sv]
// Input and result channels of the cache controller.
// Depends on mcc_pkg for field widths.
`default_nettype none

interface mcc_in_if;
	logic                        valid;
	logic                        ready;
	logic [2:0]                  action;
	logic [mcc_pkg::ADDR_W-1:0]  addr;
	logic [1:0]                  snoop_op;
	logic [mcc_pkg::ID_W-1:0]    snoop_sender;
	logic [mcc_pkg::ID_W-1:0]    snoop_receiver;
	logic                        ack_source;

	modport source (output valid, action, addr, snoop_op, snoop_sender, snoop_receiver,
		ack_source, input ready);
	modport sink (input valid, action, addr, snoop_op, snoop_sender, snoop_receiver,
		ack_source, output ready);
endinterface

interface mcc_out_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  out_kind;
	logic [1:0]                  req_op;
	logic [1:0]                  req_target;
	logic [mcc_pkg::ADDR_W-1:0]  req_addr;
	logic [mcc_pkg::ID_W-1:0]    req_receiver;
	logic                        was_hit;

	modport source (output valid, out_kind, req_op, req_target, req_addr, req_receiver,
		was_hit, input ready);
	modport sink (input valid, out_kind, req_op, req_target, req_addr, req_receiver,
		was_hit, output ready);
endinterface

`default_nettype wire

[design/mcc_ctrl.sv]
// Sequencing state machine: clear pass, accept, execute.
// Depends on mcc_pkg; drives the datapath through dp_cmd_t.
`default_nettype none

module mcc_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  mcc_pkg::dp_status_t  status,
	output mcc_pkg::dp_cmd_t     cmd
);

	mcc_pkg::ctl_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mcc_pkg::CS_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mcc_pkg::CS_CLEAR: begin
				if (status.clear_done) state_d = mcc_pkg::CS_IDLE;
			end
			mcc_pkg::CS_IDLE: begin
				if (in_valid) state_d = mcc_pkg::CS_EXEC;
			end
			mcc_pkg::CS_EXEC: begin
				if (!status.out_blocked) state_d = mcc_pkg::CS_IDLE;
			end
			default: state_d = mcc_pkg::CS_CLEAR;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			mcc_pkg::CS_CLEAR: cmd.clear = 1'b1;
			mcc_pkg::CS_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			mcc_pkg::CS_EXEC: cmd.commit = !status.out_blocked;
			default: cmd = '0;
		endcase
	end

`ifndef NO_ASSERTIONS
	a_load_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == mcc_pkg::CS_EXEC)
		else $error("load did not enter execute");
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !cmd.commit && !cmd.clear)
		else $error("ready while busy");
	a_clear_once: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mcc_pkg::CS_CLEAR) |=> state_q != mcc_pkg::CS_CLEAR)
		else $error("clear pass restarted");
`endif

endmodule

`default_nettype wire

[design/mcc_dp.sv]
// Datapath: set memories, pending-miss registers, MOESI/LRU update, result register.
// Depends on mcc_pkg and mcc_out_if; sequenced by mcc_ctrl.
`default_nettype none

module mcc_dp #(
	parameter int NUM_SETS  = mcc_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS  = mcc_pkg::NUM_WAYS_DEF,
	parameter int ADDR_BITS = mcc_pkg::ADDR_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  mcc_pkg::dp_cmd_t             cmd,
	output mcc_pkg::dp_status_t          status,
	input  wire [mcc_pkg::ID_W-1:0]      cache_id,
	input  wire [2:0]                    action,
	input  wire [mcc_pkg::ADDR_W-1:0]    addr,
	input  wire [1:0]                    snoop_op,
	input  wire [mcc_pkg::ID_W-1:0]      snoop_sender,
	input  wire [mcc_pkg::ID_W-1:0]      snoop_receiver,
	input  wire                          ack_source,
	mcc_out_if.source                    out_ch
);

	localparam int LS = mcc_pkg::LINE_SHIFT;
	localparam int AW = (ADDR_BITS < mcc_pkg::ADDR_W) ? ADDR_BITS : mcc_pkg::ADDR_W;
	localparam int SB = $clog2(NUM_SETS);
	localparam int TW = AW - LS - SB;
	localparam int RW = (NUM_WAYS > 1) ? $clog2(NUM_WAYS) : 1;
	localparam int CW = $clog2(NUM_WAYS + 1);
	localparam logic [mcc_pkg::ADDR_W-1:0] AMASK = (ADDR_BITS >= mcc_pkg::ADDR_W) ? '1 :
		mcc_pkg::ADDR_W'((64'd1 << ADDR_BITS) - 64'd1);
	localparam logic [RW-1:0] TAIL_RANK = RW'(NUM_WAYS - 1);
	localparam logic [CW-1:0] FULL_CNT  = CW'(NUM_WAYS);

	typedef logic [NUM_WAYS-1:0][TW-1:0] tag_row_t;
	typedef logic [NUM_WAYS-1:0][2:0]    st_row_t;
	typedef logic [NUM_WAYS-1:0][RW-1:0] rk_row_t;

	// set memories
	tag_row_t        mem_tag [NUM_SETS];
	st_row_t         mem_st  [NUM_SETS];
	rk_row_t         mem_rk  [NUM_SETS];
	logic [CW-1:0]   mem_cnt [NUM_SETS];

	tag_row_t        rd_tag_q;
	st_row_t         rd_st_q;
	rk_row_t         rd_rk_q;
	logic [CW-1:0]   rd_cnt_q;

	// item held for execution
	logic [2:0]                  act_q;
	logic [mcc_pkg::ADDR_W-1:0]  a_q;
	logic [1:0]                  op_q;
	logic [mcc_pkg::ID_W-1:0]    snd_q;
	logic [mcc_pkg::ID_W-1:0]    rcv_q;
	logic                        asrc_q;
	logic [SB-1:0]               set_q;

	// pending cpu access
	mcc_pkg::phase_t             ph_q, ph_n;
	logic [mcc_pkg::ADDR_W-1:0]  pa_q, pa_n;
	logic [RW-1:0]               pw_q, pw_n;
	logic                        pwr_q, pwr_n;
	logic                        pfc_q, pfc_n;

	logic [SB-1:0]               clr_q;

	// next row and result
	tag_row_t                    tg;
	st_row_t                     st;
	rk_row_t                     rk;
	logic [CW-1:0]               cnt;
	logic                        r_valid;
	logic [1:0]                  r_kind, r_op, r_tgt;
	logic [mcc_pkg::ADDR_W-1:0]  r_addr;
	logic [mcc_pkg::ID_W-1:0]    r_recv;
	logic                        r_hit;

	logic                        out_valid_q;
	logic [1:0]                  out_kind_q, req_op_q, req_target_q;
	logic [mcc_pkg::ADDR_W-1:0]  req_addr_q;
	logic [mcc_pkg::ID_W-1:0]    req_receiver_q;
	logic                        was_hit_q;

	logic [mcc_pkg::ADDR_W-1:0]  a_in;
	logic [SB-1:0]               rd_set;
	logic [SB-1:0]               wr_set;
	logic                        row_we;
	st_row_t                     wr_st;
	rk_row_t                     wr_rk;
	logic [CW-1:0]               wr_cnt;
	rk_row_t                     reset_rk;

	function automatic rk_row_t f_touch(rk_row_t r, logic [RW-1:0] w);
		rk_row_t o;
		o = r;
		for (int k = 0; k < NUM_WAYS; k++) begin
			if (r[k] < r[w]) o[k] = r[k] + 1'b1;
		end
		o[w] = '0;
		return o;
	endfunction

	function automatic rk_row_t f_to_tail(rk_row_t r, logic [RW-1:0] w);
		rk_row_t o;
		o = r;
		for (int k = 0; k < NUM_WAYS; k++) begin
			if (r[k] > r[w]) o[k] = r[k] - 1'b1;
		end
		o[w] = TAIL_RANK;
		return o;
	endfunction

	function automatic logic [RW-1:0] f_tail(rk_row_t r);
		logic [RW-1:0] best;
		best = '0;
		for (int k = 0; k < NUM_WAYS; k++) begin
			if (r[k] >= r[best]) best = RW'(k);
		end
		return best;
	endfunction

	function automatic logic [RW-1:0] f_free(st_row_t s, rk_row_t r);
		logic [RW-1:0] fw;
		logic          found;
		fw    = f_tail(r);
		found = 1'b0;
		for (int k = 0; k < NUM_WAYS; k++) begin
			if (!found && s[k] == mcc_pkg::ST_I) begin
				fw    = RW'(k);
				found = 1'b1;
			end
		end
		return fw;
	endfunction

	function automatic void f_inval(inout st_row_t s, inout rk_row_t r,
		inout logic [CW-1:0] c, input logic [RW-1:0] w);
		if (s[w] != mcc_pkg::ST_I) begin
			s[w] = mcc_pkg::ST_I;
			if (c != '0) c = c - 1'b1;
			r = f_to_tail(r, w);
		end
	endfunction

	function automatic logic [mcc_pkg::ADDR_W-1:0] f_line(logic [mcc_pkg::ADDR_W-1:0] x);
		return {x[mcc_pkg::ADDR_W-1:LS], LS'(0)};
	endfunction

	assign a_in   = addr & AMASK;
	assign rd_set = (action == mcc_pkg::ACT_RD || action == mcc_pkg::ACT_WR ||
		action == mcc_pkg::ACT_SNOOP) ? a_in[LS +: SB] : pa_q[LS +: SB];

	always_comb begin
		for (int k = 0; k < NUM_WAYS; k++) reset_rk[k] = RW'(k);
	end

	assign row_we = cmd.clear || cmd.commit;
	assign wr_set = cmd.clear ? clr_q : set_q;
	assign wr_st  = cmd.clear ? '0 : st;
	assign wr_rk  = cmd.clear ? reset_rk : rk;
	assign wr_cnt = cmd.clear ? '0 : cnt;

	always_ff @(posedge clk) begin
		if (cmd.commit) mem_tag[set_q] <= tg;
		if (cmd.load) rd_tag_q <= mem_tag[rd_set];
	end

	always_ff @(posedge clk) begin
		if (row_we) begin
			mem_st[wr_set]  <= wr_st;
			mem_rk[wr_set]  <= wr_rk;
			mem_cnt[wr_set] <= wr_cnt;
		end
		if (cmd.load) begin
			rd_st_q  <= mem_st[rd_set];
			rd_rk_q  <= mem_rk[rd_set];
			rd_cnt_q <= mem_cnt[rd_set];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q  <= action;
			a_q    <= a_in;
			op_q   <= snoop_op;
			snd_q  <= snoop_sender;
			rcv_q  <= snoop_receiver;
			asrc_q <= ack_source;
			set_q  <= rd_set;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (cmd.clear) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	assign status.clear_done  = cmd.clear && (clr_q == SB'(NUM_SETS - 1));
	assign status.out_blocked = out_valid_q && !out_ch.ready;

	// execute one item on the fetched set
	always_comb begin
		logic          hit, do_miss, do_fill;
		logic [RW-1:0] hw, fw, vw;
		logic [TW-1:0] tag_a;

		tg = rd_tag_q;
		st = rd_st_q;
		rk = rd_rk_q;
		cnt = rd_cnt_q;
		ph_n = ph_q;
		pa_n = pa_q;
		pw_n = pw_q;
		pwr_n = pwr_q;
		pfc_n = pfc_q;
		r_valid = 1'b0;
		r_kind = mcc_pkg::OUT_DONE;
		r_op = mcc_pkg::BUS_PRD;
		r_tgt = mcc_pkg::TGT_ALL;
		r_addr = '0;
		r_recv = '0;
		r_hit = 1'b0;
		do_miss = 1'b0;
		do_fill = 1'b0;
		fw = '0;
		vw = '0;

		tag_a = a_q[LS+SB +: TW];
		hit = 1'b0;
		hw = '0;
		for (int k = 0; k < NUM_WAYS; k++) begin
			if (!hit && st[k] != mcc_pkg::ST_I && tg[k] == tag_a) begin
				hit = 1'b1;
				hw  = RW'(k);
			end
		end

		unique case (act_q)
			mcc_pkg::ACT_RD, mcc_pkg::ACT_WR: begin
				if (ph_q != mcc_pkg::PH_IDLE) begin
					r_valid = 1'b1;
					r_kind  = mcc_pkg::OUT_BUSY;
				end else begin
					pa_n  = a_q;
					pwr_n = act_q[0];
					if (!hit) begin
						do_miss = 1'b1;
					end else if (act_q == mcc_pkg::ACT_RD || st[hw] == mcc_pkg::ST_E ||
						st[hw] == mcc_pkg::ST_M) begin
						if (act_q == mcc_pkg::ACT_WR) st[hw] = mcc_pkg::ST_M;
						rk = f_touch(rk, hw);
						r_valid = 1'b1;
						r_hit   = 1'b1;
					end else begin
						pw_n    = hw;
						ph_n    = mcc_pkg::PH_UPH_ACK;
						r_valid = 1'b1;
						r_kind  = mcc_pkg::OUT_REQ;
						r_op    = mcc_pkg::BUS_PWR;
						r_addr  = f_line(a_q);
					end
				end
			end
			mcc_pkg::ACT_SNOOP: begin
				if (hit && op_q != mcc_pkg::BUS_NONE) begin
					if (op_q == mcc_pkg::BUS_PWR) begin
						f_inval(st, rk, cnt, hw);
					end else begin
						if (op_q == mcc_pkg::BUS_XFER && rcv_q == cache_id) begin
							r_valid = 1'b1;
							r_kind  = mcc_pkg::OUT_REQ;
							r_op    = mcc_pkg::BUS_XFER;
							r_tgt   = mcc_pkg::TGT_ONE;
							r_addr  = f_line(a_q);
							r_recv  = snd_q;
						end
						if (st[hw] == mcc_pkg::ST_E) st[hw] = mcc_pkg::ST_S;
						else if (st[hw] == mcc_pkg::ST_M) st[hw] = mcc_pkg::ST_O;
					end
				end
			end
			mcc_pkg::ACT_ACK: begin
				unique case (ph_q)
					mcc_pkg::PH_WB_ACK: ph_n = mcc_pkg::PH_WB_DATA;
					mcc_pkg::PH_FILL_ACK: begin
						pfc_n    = asrc_q;
						st[pw_q] = asrc_q ? mcc_pkg::ST_S : mcc_pkg::ST_E;
						ph_n     = mcc_pkg::PH_FILL_DATA;
					end
					mcc_pkg::PH_UPH_ACK, mcc_pkg::PH_UPM_ACK: begin
						if (st[pw_q] == mcc_pkg::ST_I) begin
							do_miss = 1'b1;
						end else begin
							st[pw_q] = mcc_pkg::ST_M;
							rk = f_touch(rk, pw_q);
							ph_n = mcc_pkg::PH_IDLE;
							r_valid = 1'b1;
							r_hit = (ph_q == mcc_pkg::PH_UPH_ACK);
						end
					end
					default: ph_n = ph_q;
				endcase
			end
			mcc_pkg::ACT_DONE: begin
				if (ph_q == mcc_pkg::PH_WB_DATA) begin
					f_inval(st, rk, cnt, pw_q);
					do_fill = 1'b1;
					fw = f_free(st, rk);
				end else if (ph_q == mcc_pkg::PH_FILL_DATA) begin
					if (st[pw_q] == mcc_pkg::ST_I) begin
						if (pwr_q) begin
							do_fill = 1'b1;
							fw = pw_q;
						end else begin
							ph_n = mcc_pkg::PH_IDLE;
							r_valid = 1'b1;
						end
					end else if (!pwr_q) begin
						ph_n = mcc_pkg::PH_IDLE;
						r_valid = 1'b1;
					end else if (st[pw_q] == mcc_pkg::ST_S) begin
						ph_n = mcc_pkg::PH_UPM_ACK;
						r_valid = 1'b1;
						r_kind = mcc_pkg::OUT_REQ;
						r_op = mcc_pkg::BUS_PWR;
						r_addr = f_line(pa_q);
					end else begin
						st[pw_q] = mcc_pkg::ST_M;
						ph_n = mcc_pkg::PH_IDLE;
						r_valid = 1'b1;
					end
				end
			end
			default: r_valid = 1'b0;
		endcase

		// miss: in a full set, write back a dirty LRU victim or free a clean one and allocate; else allocate
		if (do_miss) begin
			if (cnt >= FULL_CNT) begin
				vw = f_tail(rk);
				if (st[vw] == mcc_pkg::ST_M || st[vw] == mcc_pkg::ST_O) begin
					pw_n = vw;
					ph_n = mcc_pkg::PH_WB_ACK;
					r_valid = 1'b1;
					r_kind = mcc_pkg::OUT_REQ;
					r_op = mcc_pkg::BUS_PWR;
					r_tgt = mcc_pkg::TGT_MEM;
					r_addr = mcc_pkg::ADDR_W'({tg[vw], set_q, LS'(0)});
				end else begin
					f_inval(st, rk, cnt, vw);
					do_fill = 1'b1;
					fw = f_free(st, rk);
				end
			end else begin
				do_fill = 1'b1;
				fw = f_free(st, rk);
			end
		end

		if (do_fill) begin
			tg[fw] = pa_n[LS+SB +: TW];
			st[fw] = mcc_pkg::ST_I;
			rk = f_touch(rk, fw);
			if (cnt < FULL_CNT) cnt = cnt + 1'b1;
			pw_n = fw;
			ph_n = mcc_pkg::PH_FILL_ACK;
			r_valid = 1'b1;
			r_kind = mcc_pkg::OUT_REQ;
			r_op = mcc_pkg::BUS_PRD;
			r_tgt = mcc_pkg::TGT_ALL;
			r_addr = f_line(pa_n);
			r_recv = '0;
			r_hit = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= mcc_pkg::PH_IDLE;
			pa_q  <= '0;
			pw_q  <= '0;
			pwr_q <= 1'b0;
			pfc_q <= 1'b0;
		end else if (cmd.commit) begin
			ph_q  <= ph_n;
			pa_q  <= pa_n;
			pw_q  <= pw_n;
			pwr_q <= pwr_n;
			pfc_q <= pfc_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit && r_valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && r_valid) begin
			out_kind_q     <= r_kind;
			req_op_q       <= r_op;
			req_target_q   <= r_tgt;
			req_addr_q     <= r_addr;
			req_receiver_q <= r_recv;
			was_hit_q      <= r_hit;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_kind     = out_kind_q;
	assign out_ch.req_op       = req_op_q;
	assign out_ch.req_target   = req_target_q;
	assign out_ch.req_addr     = req_addr_q;
	assign out_ch.req_receiver = req_receiver_q;
	assign out_ch.was_hit      = was_hit_q;

`ifndef NO_ASSERTIONS
	a_commit_clear: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.commit && cmd.clear))
		else $error("commit during clear pass");
	a_busy_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && r_valid && r_kind == mcc_pkg::OUT_BUSY) |-> ph_q != mcc_pkg::PH_IDLE)
		else $error("busy reject with no access pending");
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> cnt <= FULL_CNT)
		else $error("set count overflow");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && r_valid) |-> !status.out_blocked)
		else $error("result register overwritten");
`endif

endmodule

`default_nettype wire

[design/moesi_cache_controller.sv]
// MOESI snooping cache controller top level: APB register, controller, datapath.
// Each item is accepted with a set memory read, then executed, which writes back
// the set; one item is in flight, so no new item is accepted until the last one is done,
// and execution stalls while the result register is still held by the receiver.
// After reset a clearing pass over all NUM_SETS sets initializes line states, LRU ranks
// and set counts; no item is accepted during it. Configuration writes are taken always.
`default_nettype none

module moesi_cache_controller #(
	parameter int NUM_SETS  = mcc_pkg::NUM_SETS_DEF,
	parameter int NUM_WAYS  = mcc_pkg::NUM_WAYS_DEF,
	parameter int ADDR_BITS = mcc_pkg::ADDR_BITS_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	mcc_in_if.sink                       in_ch,
	mcc_out_if.source                    out_ch,
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [mcc_pkg::CFG_AW-1:0]    paddr,
	input  wire [mcc_pkg::APB_DW-1:0]    pwdata,
	output logic [mcc_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);

	logic [mcc_pkg::ID_W-1:0] cache_id_q;
	mcc_pkg::dp_cmd_t         cmd;
	mcc_pkg::dp_status_t      status;
	logic                     in_ready;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cache_id_q <= '0;
		end else if (psel && penable && pwrite && paddr == mcc_pkg::REG_CACHE_ID) begin
			cache_id_q <= pwdata[mcc_pkg::ID_W-1:0];
		end
	end

	assign prdata = (paddr == mcc_pkg::REG_CACHE_ID) ?
		mcc_pkg::APB_DW'(cache_id_q) : '0;

	assign in_ch.ready = in_ready;

	mcc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.status   (status),
		.cmd      (cmd)
	);

	mcc_dp #(
		.NUM_SETS  (NUM_SETS),
		.NUM_WAYS  (NUM_WAYS),
		.ADDR_BITS (ADDR_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.cache_id       (cache_id_q),
		.action         (in_ch.action),
		.addr           (in_ch.addr),
		.snoop_op       (in_ch.snoop_op),
		.snoop_sender   (in_ch.snoop_sender),
		.snoop_receiver (in_ch.snoop_receiver),
		.ack_source     (in_ch.ack_source),
		.out_ch         (out_ch)
	);

endmodule

`default_nettype wire

[sim/testbench.sv]
// Self-checking testbench for the MOESI snooping cache controller.
// Depends on mcc_pkg, mcc_in_if, mcc_out_if and moesi_cache_controller.
`timescale 1ns / 100ps

module testbench;

	typedef struct {
		logic [2:0]  action;
		logic [31:0] addr;
		logic [1:0]  sop;
		logic [3:0]  sender;
		logic [3:0]  receiver;
		logic        src;
	} cache_op_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  op;
		logic [1:0]  tgt;
		logic [31:0] addr;
		logic [3:0]  recv;
		logic        hit;
	} bus_reply_t;

	localparam int WAYS = 4;
	localparam int SETS = 128;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite, pready;
	logic [mcc_pkg::CFG_AW-1:0] paddr;
	logic [mcc_pkg::APB_DW-1:0] pwdata, prdata;

	mcc_in_if  in_ch();
	mcc_out_if out_ch();

	moesi_cache_controller DUT (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	cache_op_t  op_queue[$];
	bus_reply_t reply_queue[$];
	cache_op_t  drv_op;
	int         err_count;
	int         src_idle_pct, snk_idle_pct;
	bit         hold_armed, hold_used;
	int         hold_left;
	logic [3:0] cur_id;

	// coherence model state
	logic [19:0]     m_tag[SETS*WAYS];
	logic [2:0]      m_state[SETS*WAYS];
	logic            m_filled[SETS*WAYS];
	logic [1:0]      m_rank[SETS*WAYS];
	logic [2:0]      m_count[SETS];
	mcc_pkg::phase_t m_phase;
	logic [31:0]     m_paddr;
	logic [1:0]      m_pway;
	logic            m_pwrite;
	logic            m_pfrom;
	logic [3:0]      m_id;

	task automatic put_op(cache_op_t c);
		op_queue.insert(op_queue.size(), c);
	endtask

	function automatic bus_reply_t mk(logic [1:0] kind, logic [1:0] op, logic [1:0] tgt,
		logic [31:0] addr, logic [3:0] recv, logic hit);
		bus_reply_t r;
		r.kind = kind; r.op = op; r.tgt = tgt; r.addr = addr; r.recv = recv; r.hit = hit;
		return r;
	endfunction

	function automatic int lookup(int s, logic [19:0] tag);
		for (int w = 0; w < WAYS; w++)
			if (m_state[s*WAYS+w] != mcc_pkg::ST_I && m_tag[s*WAYS+w] == tag)
				return w;
		return -1;
	endfunction

	function automatic void touch(int s, int w);
		logic [1:0] r;
		r = m_rank[s*WAYS+w];
		for (int k = 0; k < WAYS; k++)
			if (m_rank[s*WAYS+k] < r)
				m_rank[s*WAYS+k]++;
		m_rank[s*WAYS+w] = '0;
	endfunction

	function automatic int lru_way(int s);
		int b;
		b = 0;
		for (int w = 0; w < WAYS; w++)
			if (m_rank[s*WAYS+w] >= m_rank[s*WAYS+b])
				b = w;
		return b;
	endfunction

	function automatic int alloc_way(int s);
		for (int w = 0; w < WAYS; w++)
			if (m_state[s*WAYS+w] == mcc_pkg::ST_I)
				return w;
		return lru_way(s);
	endfunction

	function automatic void drop_line(int s, int w);
		logic [1:0] r;
		if (m_state[s*WAYS+w] != mcc_pkg::ST_I) begin
			m_state[s*WAYS+w] = mcc_pkg::ST_I;
			m_filled[s*WAYS+w] = 1'b0;
			if (m_count[s] > 0)
				m_count[s]--;
			r = m_rank[s*WAYS+w];
			for (int k = 0; k < WAYS; k++)
				if (m_rank[s*WAYS+k] > r)
					m_rank[s*WAYS+k]--;
			m_rank[s*WAYS+w] = 2'(WAYS - 1);
		end
	endfunction

	function automatic bus_reply_t fill_line(int s, int w);
		m_tag[s*WAYS+w] = m_paddr[31:12];
		m_state[s*WAYS+w] = mcc_pkg::ST_I;
		m_filled[s*WAYS+w] = 1'b0;
		touch(s, w);
		if (m_count[s] < WAYS)
			m_count[s]++;
		m_pway = 2'(w);
		m_phase = mcc_pkg::PH_FILL_ACK;
		return mk(mcc_pkg::OUT_REQ, mcc_pkg::BUS_PRD, mcc_pkg::TGT_ALL,
			{m_paddr[31:5], 5'b0}, '0, 1'b0);
	endfunction

	function automatic bus_reply_t miss();
		int s, v;
		s = int'(m_paddr[11:5]);
		if (m_count[s] >= WAYS) begin
			v = lru_way(s);
			if (m_state[s*WAYS+v] == mcc_pkg::ST_M || m_state[s*WAYS+v] == mcc_pkg::ST_O) begin
				m_pway = 2'(v);
				m_phase = mcc_pkg::PH_WB_ACK;
				return mk(mcc_pkg::OUT_REQ, mcc_pkg::BUS_PWR, mcc_pkg::TGT_MEM,
					{m_tag[s*WAYS+v], 7'(s), 5'b0}, '0, 1'b0);
			end
			drop_line(s, v);
		end
		return fill_line(s, alloc_way(s));
	endfunction

	function automatic bus_reply_t complete(logic hit);
		m_phase = mcc_pkg::PH_IDLE;
		return mk(mcc_pkg::OUT_DONE, mcc_pkg::BUS_PRD, mcc_pkg::TGT_ALL, '0, '0, hit);
	endfunction

	// returns 1 when the transaction produces a reply
	function automatic bit predict(cache_op_t c, output bus_reply_t r);
		int s, w, ps, pw, pi, i;
		bit got;
		s = int'(c.addr[11:5]);
		ps = int'(m_paddr[11:5]);
		pw = int'(m_pway);
		pi = ps*WAYS + pw;
		r = '0;
		got = 1'b0;
		case (c.action)
			mcc_pkg::ACT_RD, mcc_pkg::ACT_WR: begin
				if (m_phase != mcc_pkg::PH_IDLE) begin
					r = mk(mcc_pkg::OUT_BUSY, '0, '0, '0, '0, 1'b0);
					return 1;
				end
				w = lookup(s, c.addr[31:12]);
				m_paddr = c.addr;
				m_pwrite = (c.action == mcc_pkg::ACT_WR);
				if (w < 0) begin
					r = miss();
					return 1;
				end
				i = s*WAYS + w;
				if (c.action == mcc_pkg::ACT_RD || m_state[i] == mcc_pkg::ST_E ||
					m_state[i] == mcc_pkg::ST_M) begin
					if (c.action == mcc_pkg::ACT_WR)
						m_state[i] = mcc_pkg::ST_M;
					touch(s, w);
					r = mk(mcc_pkg::OUT_DONE, '0, '0, '0, '0, 1'b1);
					return 1;
				end
				m_pway = 2'(w);
				m_phase = mcc_pkg::PH_UPH_ACK;
				r = mk(mcc_pkg::OUT_REQ, mcc_pkg::BUS_PWR, mcc_pkg::TGT_ALL,
					{c.addr[31:5], 5'b0}, '0, 1'b0);
				return 1;
			end
			mcc_pkg::ACT_SNOOP: begin
				w = lookup(s, c.addr[31:12]);
				if (w < 0 || c.sop == mcc_pkg::BUS_NONE)
					return 0;
				i = s*WAYS + w;
				if (c.sop == mcc_pkg::BUS_PWR) begin
					drop_line(s, w);
					return 0;
				end
				if (c.sop == mcc_pkg::BUS_XFER && c.receiver == m_id) begin
					r = mk(mcc_pkg::OUT_REQ, mcc_pkg::BUS_XFER, mcc_pkg::TGT_ONE,
						{c.addr[31:5], 5'b0}, c.sender, 1'b0);
					got = 1'b1;
				end
				if (m_state[i] == mcc_pkg::ST_E)
					m_state[i] = mcc_pkg::ST_S;
				else if (m_state[i] == mcc_pkg::ST_M)
					m_state[i] = mcc_pkg::ST_O;
				return got;
			end
			mcc_pkg::ACT_ACK: begin
				case (m_phase)
					mcc_pkg::PH_WB_ACK: m_phase = mcc_pkg::PH_WB_DATA;
					mcc_pkg::PH_FILL_ACK: begin
						m_pfrom = c.src;
						m_state[pi] = c.src ? mcc_pkg::ST_S : mcc_pkg::ST_E;
						m_phase = mcc_pkg::PH_FILL_DATA;
					end
					mcc_pkg::PH_UPH_ACK, mcc_pkg::PH_UPM_ACK: begin
						if (m_state[pi] == mcc_pkg::ST_I) begin
							r = miss();
							return 1;
						end
						m_state[pi] = mcc_pkg::ST_M;
						touch(ps, pw);
						r = complete(m_phase == mcc_pkg::PH_UPH_ACK);
						return 1;
					end
					default: ;
				endcase
				return 0;
			end
			mcc_pkg::ACT_DONE: begin
				if (m_phase == mcc_pkg::PH_WB_DATA) begin
					drop_line(ps, pw);
					r = fill_line(ps, alloc_way(ps));
					return 1;
				end
				if (m_phase == mcc_pkg::PH_FILL_DATA) begin
					if (m_state[pi] == mcc_pkg::ST_I) begin
						r = m_pwrite ? fill_line(ps, pw) : complete(1'b0);
						return 1;
					end
					m_filled[pi] = 1'b1;
					if (!m_pwrite) begin
						r = complete(1'b0);
						return 1;
					end
					if (m_state[pi] == mcc_pkg::ST_S) begin
						m_phase = mcc_pkg::PH_UPM_ACK;
						r = mk(mcc_pkg::OUT_REQ, mcc_pkg::BUS_PWR, mcc_pkg::TGT_ALL,
							{m_paddr[31:5], 5'b0}, '0, 1'b0);
						return 1;
					end
					m_state[pi] = mcc_pkg::ST_M;
					r = complete(1'b0);
					return 1;
				end
				return 0;
			end
			default: return 0;
		endcase
	endfunction

	task automatic report(string msg);
		err_count++;
		if (err_count <= 40)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	// clock
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else if (!in_ch.valid || in_ch.ready) begin
			if (op_queue.size() > 0 && $urandom_range(99) >= src_idle_pct) begin
				drv_op = op_queue.pop_front();
				in_ch.valid <= 1'b1;
				in_ch.action <= drv_op.action;
				in_ch.addr <= drv_op.addr;
				in_ch.snoop_op <= drv_op.sop;
				in_ch.snoop_sender <= drv_op.sender;
				in_ch.snoop_receiver <= drv_op.receiver;
				in_ch.ack_source <= drv_op.src;
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	// receiver, with one long hold-off when armed
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_left <= 0;
			hold_used <= 1'b0;
		end else if (hold_armed && !hold_used) begin
			hold_used <= 1'b1;
			hold_left <= 400;
			out_ch.ready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	// predict on every accepted input transaction
	always @(posedge clk) begin
		cache_op_t c;
		bus_reply_t r;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			c.action = in_ch.action;
			c.addr = in_ch.addr;
			c.sop = in_ch.snoop_op;
			c.sender = in_ch.snoop_sender;
			c.receiver = in_ch.snoop_receiver;
			c.src = in_ch.ack_source;
			if (predict(c, r))
				reply_queue.insert(reply_queue.size(), r);
		end
	end

	// check every accepted result transaction
	always @(posedge clk) begin
		bus_reply_t e;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (reply_queue.size() == 0) begin
				report("result with nothing expected");
			end else begin
				e = reply_queue.pop_front();
				if (out_ch.out_kind !== e.kind)
					report($sformatf("out_kind %0d exp %0d", out_ch.out_kind, e.kind));
				if (out_ch.req_op !== e.op)
					report($sformatf("req_op %0d exp %0d", out_ch.req_op, e.op));
				if (out_ch.req_target !== e.tgt)
					report($sformatf("req_target %0d exp %0d", out_ch.req_target, e.tgt));
				if (out_ch.req_addr !== e.addr)
					report($sformatf("req_addr %h exp %h", out_ch.req_addr, e.addr));
				if (out_ch.req_receiver !== e.recv)
					report($sformatf("req_receiver %0d exp %0d", out_ch.req_receiver, e.recv));
				if (out_ch.was_hit !== e.hit)
					report($sformatf("was_hit %0d exp %0d", out_ch.was_hit, e.hit));
			end
		end
	end

	function automatic cache_op_t mkop(logic [2:0] action, logic [31:0] addr,
		logic [1:0] sop = mcc_pkg::BUS_PRD, logic [3:0] sender = '0,
		logic [3:0] receiver = '0, logic src = 1'b0);
		cache_op_t c;
		c.action = action; c.addr = addr; c.sop = sop;
		c.sender = sender; c.receiver = receiver; c.src = src;
		return c;
	endfunction

	// addresses crowd a few sets and tags so that hits, evictions and snoop hits occur
	function automatic logic [31:0] pick_addr();
		logic [19:0] tag;
		logic [6:0]  set;
		tag = ($urandom_range(7) == 0) ? 20'($urandom) : 20'($urandom_range(5));
		if ($urandom_range(3) == 0)
			tag = ~tag;
		set = ($urandom_range(7) == 0) ? 7'($urandom) : 7'($urandom_range(1));
		return {tag, set, 5'($urandom)};
	endfunction

	function automatic cache_op_t rand_snoop(logic [31:0] a);
		logic [1:0] sop;
		int k;
		k = $urandom_range(9);
		sop = (k < 3) ? mcc_pkg::BUS_PRD : (k < 5) ? mcc_pkg::BUS_PWR :
			(k < 9) ? mcc_pkg::BUS_XFER : mcc_pkg::BUS_NONE;
		return mkop(mcc_pkg::ACT_SNOOP, a, sop, 4'($urandom),
			$urandom_range(1) ? cur_id : 4'($urandom), 1'($urandom));
	endfunction

	function automatic cache_op_t noise();
		return mkop(3'($urandom), $urandom, 2'($urandom), 4'($urandom), 4'($urandom),
			1'($urandom));
	endfunction

	// queue one cpu access followed by the bus events it waits for, with snoops mixed in
	task automatic add_access(ref int n);
		logic [31:0] a;
		int steps;
		a = pick_addr();
		put_op(mkop($urandom_range(1) ? mcc_pkg::ACT_WR : mcc_pkg::ACT_RD, a));
		n++;
		steps = 2 + 2*$urandom_range(2);
		for (int k = 0; k < steps; k++) begin
			if ($urandom_range(4) == 0) begin
				put_op(rand_snoop($urandom_range(1) ? a : pick_addr()));
				n++;
			end
			if ($urandom_range(15) == 0) begin
				put_op(mkop($urandom_range(1) ? mcc_pkg::ACT_RD : mcc_pkg::ACT_WR,
					pick_addr()));
				n++;
			end
			put_op(mkop((k % 2 == 0) ? mcc_pkg::ACT_ACK : mcc_pkg::ACT_DONE, pick_addr(),
				2'($urandom), 4'($urandom), 4'($urandom), 1'($urandom)));
			n++;
		end
	endtask

	task automatic wait_idle();
		while (op_queue.size() > 0 || in_ch.valid || reply_queue.size() > 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_id(logic [3:0] id);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= mcc_pkg::REG_CACHE_ID;
		pwdata <= 32'(id);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		m_id = id;
		cur_id = id;
	endtask

	task automatic run_phase(logic [3:0] id, int src_pct, int snk_pct, int count, bit hold);
		int n;
		write_id(id);
		src_idle_pct = src_pct;
		snk_idle_pct = snk_pct;
		n = 0;
		while (n < count) begin
			if ($urandom_range(9) < 7)
				add_access(n);
			else if ($urandom_range(1))
				begin put_op(rand_snoop(pick_addr())); n++; end
			else
				begin put_op(noise()); n++; end
		end
		if (hold)
			hold_armed = 1'b1;
		wait_idle();
	endtask

	initial begin
		err_count = 0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		hold_armed = 1'b0;
		cur_id = '0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_ch.valid = 1'b0; in_ch.action = mcc_pkg::ACT_RD; in_ch.addr = '0;
		in_ch.snoop_op = mcc_pkg::BUS_PRD;
		in_ch.snoop_sender = '0; in_ch.snoop_receiver = '0; in_ch.ack_source = 1'b0;
		out_ch.ready = 1'b0;
		foreach (m_tag[i]) begin
			m_tag[i] = '0;
			m_state[i] = mcc_pkg::ST_I;
			m_filled[i] = 1'b0;
			m_rank[i] = 2'(i % WAYS);
		end
		foreach (m_count[i])
			m_count[i] = '0;
		m_phase = mcc_pkg::PH_IDLE; m_paddr = '0; m_pway = '0; m_pwrite = 1'b0;
		m_pfrom = 1'b0; m_id = '0;
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;

		// directed: fill, hit, downgrades, transfer reply, upgrade, invalidate, busy, strays
		write_id(4'd3);
		put_op(mkop(mcc_pkg::ACT_ACK, 32'h0));
		put_op(mkop(mcc_pkg::ACT_DONE, 32'h0));
		put_op(mkop(mcc_pkg::ACT_RD, 32'h0000_0040));
		put_op(mkop(mcc_pkg::ACT_RD, 32'h0000_1040));
		put_op(mkop(mcc_pkg::ACT_ACK, 32'h0, mcc_pkg::BUS_PRD, 4'd0, 4'd0, 1'b0));
		put_op(mkop(mcc_pkg::ACT_DONE, 32'h0));
		put_op(mkop(mcc_pkg::ACT_WR, 32'h0000_005F));
		put_op(mkop(mcc_pkg::ACT_SNOOP, 32'h0000_0044, mcc_pkg::BUS_PRD, 4'd9, 4'd0));
		put_op(mkop(mcc_pkg::ACT_SNOOP, 32'h0000_0048, mcc_pkg::BUS_XFER, 4'd15, 4'd3));
		put_op(mkop(mcc_pkg::ACT_SNOOP, 32'h0000_0048, mcc_pkg::BUS_XFER, 4'd1, 4'd2));
		put_op(mkop(mcc_pkg::ACT_WR, 32'h0000_0040));
		put_op(mkop(mcc_pkg::ACT_ACK, 32'h0));
		put_op(mkop(mcc_pkg::ACT_SNOOP, 32'h0000_0040, mcc_pkg::BUS_PWR, 4'd2, 4'd0));
		put_op(mkop(mcc_pkg::ACT_WR, 32'hFFFF_FFFF));
		put_op(mkop(mcc_pkg::ACT_ACK, 32'h0, mcc_pkg::BUS_PRD, 4'd0, 4'd0, 1'b1));
		put_op(mkop(mcc_pkg::ACT_SNOOP, 32'hFFFF_FFE0, mcc_pkg::BUS_PWR, 4'd0, 4'd0));
		put_op(mkop(mcc_pkg::ACT_DONE, 32'h0));
		put_op(mkop(mcc_pkg::ACT_ACK, 32'h0, mcc_pkg::BUS_PRD, 4'd0, 4'd0, 1'b1));
		put_op(mkop(mcc_pkg::ACT_DONE, 32'h0));
		put_op(mkop(mcc_pkg::ACT_ACK, 32'h0));
		put_op(mkop(3'd7, 32'h1234_5678));
		put_op(mkop(3'd5, 32'h0));
		put_op(mkop(mcc_pkg::ACT_SNOOP, 32'hFFFF_FFFF, mcc_pkg::BUS_NONE, 4'd15, 4'd15, 1'b1));
		wait_idle();

		run_phase(4'd0, 0, 0, 380, 1'b0);
		run_phase(4'd15, 58, 0, 380, 1'b0);
		run_phase(4'($urandom), 0, 58, 380, 1'b1);
		run_phase(4'd5, 33, 33, 380, 1'b0);
		run_phase(4'd15, 0, 0, 380, 1'b0);

		if (err_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#5ms;
		$display("TB_ERROR");
		$finish;
	end

endmodule
